@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the receiver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) else $error(msg);

`endif

@@ rtl/core/sfr_pkg.sv @@
package sfr_pkg;

  // Frame constants
  localparam logic [7:0]  SYNC_BYTE      = 8'h55;
  localparam logic [15:0] CRC_POLY_REFL  = 16'hA001;
  localparam logic [16:0] HUNT_LIMIT_RST = 17'h10000;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd2293;
  localparam int unsigned HEADER_BYTES   = 4;

  // Configuration register indexes
  localparam logic CFG_HUNT_LIMIT  = 1'b0;
  localparam logic CFG_MAX_PAYLOAD = 1'b1;

  // Input word codes
  localparam logic FUNC_ARM  = 1'b0;
  localparam logic FUNC_BYTE = 1'b1;

  // Byte roles
  localparam logic [1:0] ROLE_SYNC    = 2'd0;
  localparam logic [1:0] ROLE_HEADER  = 2'd1;
  localparam logic [1:0] ROLE_PAYLOAD = 2'd2;
  localparam logic [1:0] ROLE_CRC     = 2'd3;

  // Status codes
  localparam logic [2:0] ST_BUSY     = 3'd0;
  localparam logic [2:0] ST_OK       = 3'd1;
  localparam logic [2:0] ST_CRC_ERR  = 3'd2;
  localparam logic [2:0] ST_TIMEOUT  = 3'd3;
  localparam logic [2:0] ST_TOO_LONG = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HUNT    = 3'd1,
    PH_HEADER  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRCLO   = 3'd4,
    PH_CRCHI   = 3'd5
  } phase_t;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [1:0]  byte_role;
    logic        last;
    logic [2:0]  status;
    logic [15:0] reply_word;
    logic [15:0] payload_length;
    logic [15:0] computed_crc;
  } out_t;

  // Byte-wide CRC-16/ARC update, LSB first
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/core/sync_frame_receiver_crc16.sv @@
// Reply-frame receiver with CRC-16/ARC check.
// Input channel (in_valid/in_ready/in_data): one word per byte. func = arm
// restarts the sync hunt and clears the frame state, giving no result;
// func = byte delivers rx_byte from the link. Bytes while idle are dropped.
// Output channel (out_valid/out_ready/out_data): one word per frame byte
// with its role, the running CRC and the header fields; the word that ends
// a frame or a failed hunt has last set and a final status.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 hunt
// limit, 1 largest payload), effective at once; write only while idle.
// The result is registered: it is on out_data in the cycle after its byte
// is accepted. One word per cycle if not stalled; the byte-wide CRC update
// and frame state step sit between the state registers and output register.
// Stall: while a result waits with out_ready low, in_ready drops; it is
// high whenever the output register is empty or is being emptied.
// Reset (rst, synchronous): block idle, not hunting, output empty, hunt
// limit 65536, largest payload 2293.
`include "assert_macros.svh"

module sync_frame_receiver_crc16 (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sfr_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sfr_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [16:0]   cfg_wdata
);
  import sfr_pkg::*;

  logic [16:0] hunt_limit;
  logic [15:0] max_payload;

  phase_t      phase, phase_next;
  logic [16:0] hunt_count, hunt_count_next;
  logic [15:0] byte_index, byte_index_next;
  logic [15:0] crc_reg, crc_reg_next;
  logic [15:0] reply_reg, reply_reg_next;
  logic [15:0] length_reg, length_reg_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;

  logic        in_fire;
  logic        res_fire;
  out_t        res;
  logic [16:0] limit_eff;
  logic [15:0] crc_upd;
  logic [7:0]  b;

  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign b         = in_data.rx_byte;
  assign limit_eff = (hunt_limit == 17'd0) ? 17'd1 : hunt_limit;
  assign crc_upd   = crc16_update(crc_reg, b);

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hunt_limit  <= HUNT_LIMIT_RST;
      max_payload <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HUNT_LIMIT:  hunt_limit  <= cfg_wdata;
        CFG_MAX_PAYLOAD: max_payload <= cfg_wdata[15:0];
        default:         hunt_limit  <= hunt_limit;
      endcase
    end
  end

  // Step the frame state for one accepted word
  always_comb begin
    phase_next        = phase;
    hunt_count_next   = hunt_count;
    byte_index_next   = byte_index;
    crc_reg_next      = crc_reg;
    reply_reg_next    = reply_reg;
    length_reg_next   = length_reg;
    crc_low_byte_next = crc_low_byte;
    res_fire          = 1'b0;
    res.byte_out      = b;
    res.byte_role     = ROLE_SYNC;
    res.last          = 1'b0;
    res.status        = ST_BUSY;

    if (in_data.func == FUNC_ARM) begin
      phase_next        = PH_HUNT;
      hunt_count_next   = '0;
      byte_index_next   = '0;
      crc_reg_next      = '0;
      reply_reg_next    = '0;
      length_reg_next   = '0;
      crc_low_byte_next = '0;
    end else begin
      case (phase)
        PH_HUNT: begin
          if (b == SYNC_BYTE) begin
            crc_reg_next    = crc16_update(16'h0000, b);
            byte_index_next = '0;
            phase_next      = PH_HEADER;
            res_fire        = 1'b1;
          end else begin
            hunt_count_next = hunt_count + 17'd1;
            if (hunt_count_next >= limit_eff) begin
              // Give up: clear the frame and report timeout
              phase_next        = PH_IDLE;
              hunt_count_next   = '0;
              byte_index_next   = '0;
              crc_reg_next      = '0;
              reply_reg_next    = '0;
              length_reg_next   = '0;
              crc_low_byte_next = '0;
              res_fire          = 1'b1;
              res.byte_out      = 8'h00;
              res.last          = 1'b1;
              res.status        = ST_TIMEOUT;
            end
          end
        end
        PH_HEADER: begin
          crc_reg_next  = crc_upd;
          res_fire      = 1'b1;
          res.byte_role = ROLE_HEADER;
          if (byte_index < 16'd2) begin
            reply_reg_next = {reply_reg[7:0], b};
          end else begin
            length_reg_next = {length_reg[7:0], b};
          end
          if (byte_index == 16'(HEADER_BYTES - 1)) begin
            byte_index_next = '0;
            if (length_reg_next > max_payload) begin
              phase_next = PH_IDLE;
              res.last   = 1'b1;
              res.status = ST_TOO_LONG;
            end else if (length_reg_next == 16'd0) begin
              phase_next = PH_CRCLO;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end else begin
            byte_index_next = byte_index + 16'd1;
          end
        end
        PH_PAYLOAD: begin
          crc_reg_next    = crc_upd;
          byte_index_next = byte_index + 16'd1;
          if (byte_index_next >= length_reg) begin
            phase_next = PH_CRCLO;
          end
          res_fire      = 1'b1;
          res.byte_role = ROLE_PAYLOAD;
        end
        PH_CRCLO: begin
          crc_low_byte_next = b;
          phase_next        = PH_CRCHI;
          res_fire          = 1'b1;
          res.byte_role     = ROLE_CRC;
        end
        PH_CRCHI: begin
          phase_next    = PH_IDLE;
          res_fire      = 1'b1;
          res.byte_role = ROLE_CRC;
          res.last      = 1'b1;
          res.status    = ({b, crc_low_byte} == crc_reg) ? ST_OK : ST_CRC_ERR;
        end
        default: begin
          // Idle or unused code: drop the byte
          phase_next = PH_IDLE;
        end
      endcase
    end

    res.reply_word     = reply_reg_next;
    res.payload_length = length_reg_next;
    res.computed_crc   = crc_reg_next;
  end

  // Advance the frame state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      hunt_count   <= '0;
      byte_index   <= '0;
      crc_reg      <= '0;
      reply_reg    <= '0;
      length_reg   <= '0;
      crc_low_byte <= '0;
    end else if (in_fire) begin
      phase        <= phase_next;
      hunt_count   <= hunt_count_next;
      byte_index   <= byte_index_next;
      crc_reg      <= crc_reg_next;
      reply_reg    <= reply_reg_next;
      length_reg   <= length_reg_next;
      crc_low_byte <= crc_low_byte_next;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && res_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_fire) begin
      out_data <= res;
    end
  end

  `ASSERT_SAME(a_last_has_status, clk, rst, out_valid && out_data.last, out_data.status != ST_BUSY, "final word without a final status")
  `ASSERT_NEXT(a_last_goes_idle, clk, rst, in_fire && res_fire && res.last, phase == PH_IDLE, "frame end did not return to idle")
  `ASSERT_SAME(a_payload_bounds, clk, rst, phase == PH_PAYLOAD, (length_reg != 16'd0) && (byte_index < length_reg), "payload counter out of range")

endmodule

@@ tb/sv/tb_sync_frame_receiver_crc16.sv @@
module tb_sync_frame_receiver_crc16;
  import sfr_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_ITEMS = 1950;
  localparam int PHASES = 6;

  // Where a scripted byte takes its value from
  localparam logic [1:0] SRC_LIT = 2'd0;
  localparam logic [1:0] SRC_CRC_LO = 2'd1;
  localparam logic [1:0] SRC_CRC_HI = 2'd2;

  localparam out_t TIMEOUT_WORD = out_t'({8'h00, ROLE_SYNC, 1'b1, ST_TIMEOUT, 48'h0});

  typedef struct packed {
    logic       func;
    logic [7:0] val;
    logic [1:0] src;
    logic       typed;
    out_t       want;
  } script_row_t;

  logic  clk;
  logic  rst;
  logic  in_valid;
  logic  in_ready;
  in_t   in_data;
  logic  out_valid;
  logic  out_ready;
  out_t  out_data;
  logic  cfg_we;
  logic  cfg_index;
  logic  [16:0] cfg_wdata;

  // Deframer state as the checker sees it
  phase_t      ph;
  logic [16:0] hunt_seen;
  logic [15:0] hdr_pos;
  logic [15:0] run_crc;
  logic [15:0] reply_acc;
  logic [15:0] len_acc;
  logic [7:0]  crc_lo_rx;
  logic [16:0] hunt_lim;
  logic [15:0] max_len;

  out_t        expected_echoes[$];
  out_t        head;
  script_row_t script[$];
  int          faults;
  int          busy_items;
  int          rx_wait;
  int          quiet;
  bit          long_hold;

  sync_frame_receiver_crc16 DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Reflected CRC-16/ARC, one data bit per step
  function automatic logic [15:0] arc_crc_byte(input logic [15:0] c, input logic [7:0] d);
    logic fb;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ d[k];
      c = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY_REFL;
      end
    end
    return c;
  endfunction

  // Mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_fault(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    faults++;
  endtask

  task automatic check_field(input string tag, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) begin
      report_fault($sformatf("%s got %h want %h", tag, got, want));
    end
  endtask

  task automatic clear_frame_state();
    hunt_seen = '0;
    hdr_pos = '0;
    run_crc = '0;
    reply_acc = '0;
    len_acc = '0;
    crc_lo_rx = '0;
  endtask

  // Advance the deframer by one accepted word; queue the echo it gives
  task automatic deframe_step(input in_t w, output bit hit, output bit produced);
    logic [7:0]  b;
    logic [7:0]  echo;
    logic [1:0]  role;
    logic        fin;
    logic [2:0]  st;
    logic [16:0] lim;
    b = w.rx_byte;
    echo = b;
    role = ROLE_SYNC;
    fin = 1'b0;
    st = ST_BUSY;
    hit = 1'b1;
    produced = 1'b0;
    if (w.func == FUNC_ARM) begin
      clear_frame_state();
      ph = PH_HUNT;
    end else begin
      case (ph)
        PH_HUNT: begin
          if (b == SYNC_BYTE) begin
            run_crc = arc_crc_byte(16'h0000, b);
            hdr_pos = '0;
            ph = PH_HEADER;
            produced = 1'b1;
          end else begin
            hunt_seen = hunt_seen + 17'd1;
            lim = (hunt_lim == '0) ? 17'd1 : hunt_lim;
            if (hunt_seen >= lim) begin
              clear_frame_state();
              ph = PH_IDLE;
              echo = 8'h00;
              fin = 1'b1;
              st = ST_TIMEOUT;
              produced = 1'b1;
            end
          end
        end
        PH_HEADER: begin
          run_crc = arc_crc_byte(run_crc, b);
          if (hdr_pos < 16'd2) begin
            reply_acc = {reply_acc[7:0], b};
          end else begin
            len_acc = {len_acc[7:0], b};
          end
          hdr_pos = hdr_pos + 16'd1;
          role = ROLE_HEADER;
          produced = 1'b1;
          if (hdr_pos == 16'(HEADER_BYTES)) begin
            hdr_pos = '0;
            if (len_acc > max_len) begin
              ph = PH_IDLE;
              fin = 1'b1;
              st = ST_TOO_LONG;
            end else begin
              ph = (len_acc == 16'd0) ? PH_CRCLO : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          run_crc = arc_crc_byte(run_crc, b);
          hdr_pos = hdr_pos + 16'd1;
          if (hdr_pos >= len_acc) begin
            ph = PH_CRCLO;
          end
          role = ROLE_PAYLOAD;
          produced = 1'b1;
        end
        PH_CRCLO: begin
          crc_lo_rx = b;
          ph = PH_CRCHI;
          role = ROLE_CRC;
          produced = 1'b1;
        end
        PH_CRCHI: begin
          ph = PH_IDLE;
          role = ROLE_CRC;
          fin = 1'b1;
          st = ({b, crc_lo_rx} == run_crc) ? ST_OK : ST_CRC_ERR;
          produced = 1'b1;
        end
        default: begin
          hit = 1'b0;
        end
      endcase
    end
    if (produced) begin
      expected_echoes.push_back(out_t'({echo, role, fin, st, reply_acc, len_acc, run_crc}));
    end
  endtask

  // Offer one word after an optional gap, hold it until taken
  task automatic send_word(input in_t w, input int gap, output bit produced);
    bit hit;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    deframe_step(w, hit, produced);
    if (hit) begin
      busy_items++;
    end
  endtask

  task automatic add_row(input logic f, input logic [7:0] v, input logic [1:0] s,
                         input logic typed, input out_t want);
    script.push_back(script_row_t'({f, v, s, typed, want}));
  endtask

  // Arm, then send a frame with random content; optionally break it off early
  task automatic send_frame(input bit cut, input bit eager);
    logic [7:0]  seq[$];
    logic [7:0]  b;
    logic [15:0] c;
    logic [15:0] len;
    logic [15:0] rp;
    logic [16:0] lim;
    int          noise;
    int          keep;
    int          cap;
    int          r;
    int          k;
    in_t         w;
    bit          got;
    lim = (hunt_lim == '0) ? 17'd1 : hunt_lim;
    cap = int'(max_len);
    noise = 0;
    if (!eager) begin
      r = $urandom_range(0, 9);
      if (r < 2 && lim <= 17'd8) begin
        noise = int'(lim);
      end else if (r < 5) begin
        noise = $urandom_range(1, 3);
      end
    end
    for (k = 0; k < noise; k++) begin
      b = 8'($urandom_range(0, 255));
      if (b == SYNC_BYTE) begin
        b = b ^ 8'h01;
      end
      seq.push_back(b);
    end
    // Pick a length: mostly short, some empty, some over the limit
    r = $urandom_range(0, 15);
    if (eager) begin
      len = 16'((cap < 40) ? cap : 40);
    end else if (r < 2 && cap < 65535) begin
      len = 16'($urandom_range(cap + 1, 65535));
    end else if (r < 4 || cap == 0) begin
      len = 16'd0;
    end else if (r == 4) begin
      len = 16'($urandom_range(1, (cap < 120) ? cap : 120));
    end else begin
      len = 16'($urandom_range(1, (cap < 12) ? cap : 12));
    end
    rp = 16'($urandom_range(0, 65535));
    seq.push_back(SYNC_BYTE);
    seq.push_back(rp[15:8]);
    seq.push_back(rp[7:0]);
    seq.push_back(len[15:8]);
    seq.push_back(len[7:0]);
    if (len > max_len) begin
      // Frame ends at the header; trailing bytes fall on an idle block
      for (k = $urandom_range(0, 2); k > 0; k--) begin
        seq.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      for (k = 0; k < len; k++) begin
        seq.push_back(8'($urandom_range(0, 255)));
      end
      c = 16'h0000;
      for (k = noise; k < seq.size(); k++) begin
        c = arc_crc_byte(c, seq[k]);
      end
      if ($urandom_range(0, 7) == 0) begin
        c = c ^ (16'h0001 << $urandom_range(0, 15));
      end
      seq.push_back(c[7:0]);
      seq.push_back(c[15:8]);
    end
    keep = cut ? $urandom_range(1, seq.size() - 1) : seq.size();
    w.func = FUNC_ARM;
    w.rx_byte = 8'($urandom_range(0, 255));
    send_word(w, eager ? 0 : pick_gap(), got);
    for (k = 0; k < keep; k++) begin
      w.func = FUNC_BYTE;
      w.rx_byte = seq[k];
      send_word(w, eager ? 0 : pick_gap(), got);
    end
  endtask

  // Stop offering, drain the block, let it settle, then write both registers
  task automatic set_limits(input logic [16:0] h, input logic [15:0] m);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_echoes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_HUNT_LIMIT;
    cfg_wdata <= h;
    @(negedge clk);
    cfg_index <= CFG_MAX_PAYLOAD;
    cfg_wdata <= {1'b0, m};
    @(negedge clk);
    cfg_we <= 1'b0;
    hunt_lim = h;
    max_len = m;
  endtask

  // Receiver: random stalls, and one long hold-off on request
  initial begin
    out_ready = 1'b0;
    rx_wait = 0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        for (int n = 1; n < HOLD_CYCLES; n++) @(negedge clk);
        long_hold = 1'b0;
      end else if (rx_wait > 0) begin
        out_ready <= 1'b0;
        rx_wait--;
      end else begin
        out_ready <= 1'b1;
        rx_wait = pick_gap();
      end
    end
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_echoes.size() == 0) begin
        report_fault($sformatf("unexpected word %h", out_data));
      end else begin
        head = expected_echoes.pop_front();
        check_field("byte_out", 16'(out_data.byte_out), 16'(head.byte_out));
        check_field("byte_role", 16'(out_data.byte_role), 16'(head.byte_role));
        check_field("last", 16'(out_data.last), 16'(head.last));
        check_field("status", 16'(out_data.status), 16'(head.status));
        check_field("reply_word", out_data.reply_word, head.reply_word);
        check_field("payload_length", out_data.payload_length, head.payload_length);
        check_field("computed_crc", out_data.computed_crc, head.computed_crc);
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long
  initial begin
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_sync_frame_receiver_crc16: done, errors");
    $finish;
  end

  initial begin
    int          i;
    int          p;
    int          r;
    in_t         w;
    bit          got;
    script_row_t row;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_HUNT_LIMIT;
    cfg_wdata = '0;
    faults = 0;
    busy_items = 0;
    long_hold = 1'b0;
    ph = PH_IDLE;
    clear_frame_state();
    hunt_lim = HUNT_LIMIT_RST;
    max_len = MAX_PAYLOAD_RST;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed script: idle byte, hunt miss and timeout, too long,
    // empty payload, good CRC, arm in the middle of a frame
    add_row(FUNC_BYTE, 8'h00, SRC_LIT, 1'b0, '0);
    add_row(FUNC_ARM, 8'hFF, SRC_LIT, 1'b0, '0);
    add_row(FUNC_BYTE, 8'hFF, SRC_LIT, 1'b0, '0);
    add_row(FUNC_BYTE, 8'hAA, SRC_LIT, 1'b1, TIMEOUT_WORD);
    add_row(FUNC_ARM, 8'h00, SRC_LIT, 1'b0, '0);
    add_row(FUNC_BYTE, SYNC_BYTE, SRC_LIT, 1'b0, '0);
    add_row(FUNC_BYTE, 8'hFF, SRC_LIT, 1'b0, '0);
    add_row(FUNC_BYTE, 8'hFF, SRC_LIT, 1'b0, '0);
    add_row(FUNC_BYTE, 8'hFF, SRC_LIT, 1'b0, '0);
    add_row(FUNC_BYTE, 8'hFF, SRC_LIT, 1'b0, '0);
    add_row(FUNC_ARM, 8'h00, SRC_LIT, 1'b0, '0);
    add_row(FUNC_BYTE, SYNC_BYTE, SRC_LIT, 1'b0, '0);
    add_row(FUNC_BYTE, 8'h00, SRC_LIT, 1'b0, '0);
    add_row(FUNC_BYTE, 8'h00, SRC_LIT, 1'b0, '0);
    add_row(FUNC_BYTE, 8'h00, SRC_LIT, 1'b0, '0);
    add_row(FUNC_BYTE, 8'h00, SRC_LIT, 1'b0, '0);
    add_row(FUNC_BYTE, 8'h00, SRC_CRC_LO, 1'b0, '0);
    add_row(FUNC_BYTE, 8'h00, SRC_CRC_HI, 1'b0, '0);
    add_row(FUNC_ARM, 8'h00, SRC_LIT, 1'b0, '0);
    add_row(FUNC_BYTE, SYNC_BYTE, SRC_LIT, 1'b0, '0);
    add_row(FUNC_BYTE, 8'h12, SRC_LIT, 1'b0, '0);
    add_row(FUNC_BYTE, 8'h34, SRC_LIT, 1'b0, '0);
    add_row(FUNC_BYTE, 8'h00, SRC_LIT, 1'b0, '0);
    add_row(FUNC_BYTE, 8'h01, SRC_LIT, 1'b0, '0);
    add_row(FUNC_BYTE, 8'h80, SRC_LIT, 1'b0, '0);
    add_row(FUNC_ARM, 8'h00, SRC_LIT, 1'b0, '0);

    set_limits(17'd2, 16'd3);
    for (i = 0; i < script.size(); i++) begin
      row = script[i];
      w.func = row.func;
      case (row.src)
        SRC_CRC_LO: begin
          w.rx_byte = run_crc[7:0];
        end
        SRC_CRC_HI: begin
          w.rx_byte = run_crc[15:8];
        end
        default: begin
          w.rx_byte = row.val;
        end
      endcase
      send_word(w, pick_gap(), got);
      // Replace the predicted word with the hand-written one
      if (row.typed) begin
        if (got) begin
          void'(expected_echoes.pop_back());
        end
        expected_echoes.push_back(row.want);
      end
    end

    // Random frames under a range of limits, extremes included
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: set_limits(HUNT_LIMIT_RST, MAX_PAYLOAD_RST);
        1: set_limits(17'd1, 16'd0);
        2: set_limits(17'd0, 16'd16);
        3: set_limits(17'h1FFFF, 16'hFFFF);
        4: set_limits(17'd5, 16'd12);
        default: set_limits(17'd3, 16'd40);
      endcase
      // Hold the receiver off while a long frame is pushed in back to back
      if (p == 0) begin
        long_hold = 1'b1;
        send_frame(1'b0, 1'b1);
      end
      while (busy_items < script.size() + (p + 1) * RANDOM_ITEMS / PHASES) begin
        r = $urandom_range(0, 19);
        if (r < 15) begin
          send_frame(1'b0, 1'b0);
        end else if (r < 17) begin
          send_frame(1'b1, 1'b0);
        end else begin
          w.func = 1'($urandom_range(0, 1));
          w.rx_byte = 8'($urandom_range(0, 255));
          send_word(w, pick_gap(), got);
        end
      end
    end

    // Drain and let any stray word show up
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_echoes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (faults == 0) begin
      $display("tb_sync_frame_receiver_crc16: done, clean");
    end else begin
      $display("tb_sync_frame_receiver_crc16: done, errors");
    end
    $finish;
  end

endmodule
